### design/jacobi_poisson_stencil_sweep_top_assert.svh
// concurrent assertion helpers, empty when synthesized
`ifndef JACOBI_POISSON_STENCIL_SWEEP_TOP_ASSERT_SVH
`define JACOBI_POISSON_STENCIL_SWEEP_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define JPSS_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("jpss assertion failed");
`define JPSS_ASSERT_NXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("jpss assertion failed");
`else
`define JPSS_ASSERT_IMP(name, clk, rst, ante, cons)
`define JPSS_ASSERT_NXT(name, clk, rst, ante, cons)
`endif
`endif

### design/jpss_pkg.sv
package jpss_pkg;

   typedef struct packed {
      logic signed [31:0] old_value;
      logic signed [31:0] vorticity;
      logic [30:0]        metric_sq;
   } req_item_type;

   typedef struct packed {
      logic [15:0]        cell_row;
      logic [10:0]        cell_col;
      logic signed [31:0] new_value;
      logic [30:0]        max_change;
      logic               sweep_done;
   } rsp_item_type;

   // classified cell handed from front to back
   typedef struct packed {
      req_item_type item;
      logic [15:0]  cell_row;
      logic         interior;
      logic         last;
      logic         clear_max;
   } task_type;

   typedef struct packed {
      logic [15:0] kappa_a;
      logic [30:0] kappa_sq;
      logic [30:0] dx_sq;
   } coef_type;

   typedef struct packed {
      logic [10:0] grid_cols;
      logic [15:0] grid_rows;
   } dims_type;

   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_KAPPA_A   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_KAPPA_SQ  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DX_SQ     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_COLS = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_ROWS = 3'd4;

   localparam logic [15:0] KAPPA_A_RST   = 16'd16384;
   localparam logic [30:0] KAPPA_SQ_RST  = 31'd65536;
   localparam logic [30:0] DX_SQ_RST     = 31'd65536;
   localparam logic [10:0] GRID_COLS_RST = 11'd1024;
   localparam logic [15:0] GRID_ROWS_RST = 16'd1024;

   localparam logic [15:0] ROWS_MAX = 16'd65534;

endpackage

### design/jpss_queue.sv
module jpss_queue
   import jpss_pkg::*;
#(
   parameter int WIDTH = 128
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata,
   output logic             full,
   output logic             empty
);

   // two entries, both waiting: the back end pops a cell as it starts work on it
   logic [WIDTH-1:0] slot_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;

   assign full  = (count_ff == 2'd2);
   assign empty = (count_ff == 2'd0);
   assign rdata = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

### design/jpss_front.sv
module jpss_front
   import jpss_pkg::*;
#(
   parameter int MAX_COLS = 1024,
   localparam int COL_W = $clog2(MAX_COLS + 2)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  req_item_type     req_data,
   input  dims_type         dims,
   input  logic             q_full,
   output logic             q_push,
   output task_type         push_task,
   output logic [COL_W-1:0] push_col
);

   logic [COL_W-1:0] col_ff, col_in;
   logic [15:0]      row_ff, row_in;
   logic [31:0]      cols_w, rows_w, width_w, height_w, c_w, r_w;
   logic [COL_W-1:0] c_cur;
   logic [15:0]      r_cur;
   logic             restart, wrap_col, wrap_row;

   assign req_stall = q_full;
   assign q_push    = req_valid && !q_full;

   always_comb begin
      if (dims.grid_cols == '0) begin
         cols_w = 32'd1;
      end else if (32'(dims.grid_cols) > 32'(MAX_COLS)) begin
         cols_w = 32'(MAX_COLS);
      end else begin
         cols_w = 32'(dims.grid_cols);
      end
      if (dims.grid_rows == '0) begin
         rows_w = 32'd1;
      end else if (dims.grid_rows > ROWS_MAX) begin
         rows_w = 32'(ROWS_MAX);
      end else begin
         rows_w = 32'(dims.grid_rows);
      end
      width_w  = cols_w + 32'd2;
      height_w = rows_w + 32'd2;

      // a shrunk grid can leave the position outside: restart the sweep
      restart = (32'(col_ff) >= width_w) || (32'(row_ff) >= height_w);
      c_cur   = restart ? '0 : col_ff;
      r_cur   = restart ? '0 : row_ff;
      c_w     = 32'(c_cur);
      r_w     = 32'(r_cur);

      wrap_col = (c_w + 32'd1) >= width_w;
      wrap_row = (r_w + 32'd1) >= height_w;

      push_task.item      = req_data;
      push_task.cell_row  = 16'(r_w - 32'd1);
      push_task.interior  = (r_w >= 32'd2) && (c_w >= 32'd1) && (c_w <= cols_w);
      push_task.last      = ((r_w - 32'd1) == rows_w) && (c_w == cols_w);
      push_task.clear_max = restart || (wrap_col && wrap_row);
      push_col            = c_cur;

      col_in = col_ff;
      row_in = row_ff;
      if (q_push) begin
         if (wrap_col) begin
            col_in = '0;
            row_in = wrap_row ? '0 : 16'(r_w + 32'd1);
         end else begin
            col_in = COL_W'(c_w + 32'd1);
            row_in = r_cur;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

endmodule

### design/jpss_back.sv
`include "jacobi_poisson_stencil_sweep_top_assert.svh"

module jpss_back
   import jpss_pkg::*;
#(
   parameter int MAX_COLS  = 1024,
   parameter int FRAC_BITS = 16,
   localparam int COL_W = $clog2(MAX_COLS + 2)
) (
   input  logic             clock,
   input  logic             reset,
   input  coef_type         coef,
   input  logic             q_empty,
   input  task_type         head_task,
   input  logic [COL_W-1:0] head_col,
   output logic             q_pop,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rsp_item_type     rsp_data
);

   localparam int STORE_DEPTH = MAX_COLS + 2;
   localparam logic signed [65:0] SUM_HI = 66'sh7FFF_FFFF_FFFF;
   localparam logic signed [65:0] SUM_LO = -SUM_HI - 66'sd1;
   localparam logic signed [64:0] NV_HI  = 65'sd2147483647;
   localparam logic signed [64:0] NV_LO  = -NV_HI - 65'sd1;

   typedef enum logic [9:0] {
      ST_IDLE  = 10'b00_0000_0001,
      ST_READ  = 10'b00_0000_0010,
      ST_EAST  = 10'b00_0000_0100,
      ST_MUL1  = 10'b00_0000_1000,
      ST_MUL2  = 10'b00_0001_0000,
      ST_SUM   = 10'b00_0010_0000,
      ST_MUL3  = 10'b00_0100_0000,
      ST_CLAMP = 10'b00_1000_0000,
      ST_DIFF  = 10'b01_0000_0000,
      ST_DONE  = 10'b10_0000_0000
   } state_type;

   state_type state_ff, state_in;

   // line buffers
   logic [31:0] cur_mem  [STORE_DEPTH];
   logic [31:0] abv_mem  [STORE_DEPTH];
   logic [31:0] vort_mem [STORE_DEPTH];
   logic [30:0] met_mem  [STORE_DEPTH];

   logic signed [31:0] cur_rd_ff, abv_rd_ff, vort_rd_ff;
   logic [30:0]        met_rd_ff;

   task_type           task_ff;
   logic [COL_W-1:0]   col_ff;
   logic signed [31:0] mid_ff, north_ff, vort_ff, west_ff;
   logic [30:0]        met_ff;
   logic signed [32:0] ew_ff, nsum_ff;
   logic [61:0]        gprod_ff;
   logic signed [64:0] ksprod_ff;
   logic signed [63:0] srcprod_ff;
   logic signed [47:0] sum_ff;
   logic signed [64:0] nvprod_ff;
   logic signed [31:0] nv_ff;
   logic [30:0]        diff_ff;
   logic [30:0]        max_ff, max_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_item_type       rsp_data_ff;

   logic               mem_rd, mem_wr, out_load, out_free;
   logic [COL_W-1:0]   rd_addr, east_addr;
   logic [COL_W:0]     east_sum;
   logic               east_out;
   logic signed [31:0] east_val, west_val;
   logic [61:0]        g_shift;
   logic [30:0]        g_sat;
   logic signed [31:0] g_s, ks_s;
   logic signed [16:0] ka_s;
   logic signed [63:0] src_sh;
   logic signed [64:0] ks_sh, nv_sh;
   logic signed [65:0] sum_wide;
   logic signed [32:0] dlt;
   logic [32:0]        mag;
   logic [30:0]        new_max;

   assign east_sum  = (COL_W + 1)'(col_ff) + (COL_W + 1)'(1);
   assign east_out  = east_sum >= (COL_W + 1)'(STORE_DEPTH);
   assign east_addr = east_out ? '0 : east_sum[COL_W-1:0];
   assign east_val  = east_out ? '0 : cur_rd_ff;
   // west neighbour is the previous cell's middle value, kept in west_ff; zero in column 0
   assign west_val  = (col_ff == '0) ? '0 : west_ff;

   assign g_shift = gprod_ff >> FRAC_BITS;
   assign g_sat   = (g_shift > 62'h7FFF_FFFF) ? 31'h7FFF_FFFF : g_shift[30:0];
   assign g_s     = signed'({1'b0, g_sat});
   assign ks_s    = signed'({1'b0, coef.kappa_sq});
   assign ka_s    = signed'({1'b0, coef.kappa_a});

   assign src_sh   = srcprod_ff >>> FRAC_BITS;
   assign ks_sh    = ksprod_ff >>> FRAC_BITS;
   assign sum_wide = 66'(src_sh) + 66'(ks_sh) + 66'(ew_ff);
   assign nv_sh    = nvprod_ff >>> FRAC_BITS;

   assign dlt     = 33'(nv_ff) - 33'(mid_ff);
   assign mag     = dlt[32] ? 33'(-dlt) : 33'(dlt);
   assign new_max = (diff_ff > max_ff) ? diff_ff : max_ff;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      state_in = state_ff;
      q_pop    = 1'b0;
      mem_rd   = 1'b0;
      mem_wr   = 1'b0;
      out_load = 1'b0;
      rd_addr  = head_col;
      max_in   = max_ff;
      case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               q_pop    = 1'b1;
               mem_rd   = 1'b1;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            mem_rd   = 1'b1;
            rd_addr  = east_addr;
            state_in = ST_EAST;
         end
         ST_EAST: begin
            mem_wr = 1'b1;
            if (task_ff.interior) begin
               state_in = ST_MUL1;
            end else begin
               if (task_ff.clear_max) begin
                  max_in = '0;
               end
               state_in = ST_IDLE;
            end
         end
         ST_MUL1:  state_in = ST_MUL2;
         ST_MUL2:  state_in = ST_SUM;
         ST_SUM:   state_in = ST_MUL3;
         ST_MUL3:  state_in = ST_CLAMP;
         ST_CLAMP: state_in = ST_DIFF;
         ST_DIFF:  state_in = ST_DONE;
         ST_DONE: begin
            if (out_free) begin
               out_load = 1'b1;
               max_in   = new_max;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         max_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         max_ff       <= max_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_wr) begin
         cur_mem[col_ff]  <= task_ff.item.old_value;
         abv_mem[col_ff]  <= mid_ff;
         vort_mem[col_ff] <= task_ff.item.vorticity;
         met_mem[col_ff]  <= task_ff.item.metric_sq;
      end
      if (mem_rd) begin
         cur_rd_ff  <= cur_mem[rd_addr];
         abv_rd_ff  <= abv_mem[rd_addr];
         vort_rd_ff <= vort_mem[rd_addr];
         met_rd_ff  <= met_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         task_ff <= head_task;
         col_ff  <= head_col;
      end
      if (state_ff == ST_READ) begin
         mid_ff   <= cur_rd_ff;
         north_ff <= abv_rd_ff;
         vort_ff  <= vort_rd_ff;
         met_ff   <= met_rd_ff;
      end
      if (state_ff == ST_EAST) begin
         ew_ff   <= 33'(east_val) + 33'(west_val);
         nsum_ff <= 33'(north_ff) + 33'(task_ff.item.old_value);
         west_ff <= mid_ff;
      end
      if (state_ff == ST_MUL1) begin
         gprod_ff  <= coef.dx_sq * met_ff;
         ksprod_ff <= ks_s * nsum_ff;
      end
      if (state_ff == ST_MUL2) begin
         srcprod_ff <= g_s * vort_ff;
      end
      if (state_ff == ST_SUM) begin
         if (sum_wide > SUM_HI) begin
            sum_ff <= SUM_HI[47:0];
         end else if (sum_wide < SUM_LO) begin
            sum_ff <= SUM_LO[47:0];
         end else begin
            sum_ff <= sum_wide[47:0];
         end
      end
      if (state_ff == ST_MUL3) begin
         nvprod_ff <= ka_s * sum_ff;
      end
      if (state_ff == ST_CLAMP) begin
         if (nv_sh > NV_HI) begin
            nv_ff <= NV_HI[31:0];
         end else if (nv_sh < NV_LO) begin
            nv_ff <= NV_LO[31:0];
         end else begin
            nv_ff <= nv_sh[31:0];
         end
      end
      if (state_ff == ST_DIFF) begin
         diff_ff <= (mag > 33'h0_7FFF_FFFF) ? 31'h7FFF_FFFF : mag[30:0];
      end
      if (out_load) begin
         rsp_data_ff.cell_row   <= task_ff.cell_row;
         rsp_data_ff.cell_col   <= 11'(col_ff);
         rsp_data_ff.new_value  <= nv_ff;
         rsp_data_ff.max_change <= new_max;
         rsp_data_ff.sweep_done <= task_ff.last;
      end
   end

   `JPSS_ASSERT_NXT(a_east_exit, clock, reset, state_ff == ST_EAST, state_ff == ST_MUL1 || state_ff == ST_IDLE)
   `JPSS_ASSERT_NXT(a_max_grows, clock, reset, out_load, rsp_data_ff.max_change >= $past(max_ff))
   `JPSS_ASSERT_IMP(a_rsp_interior, clock, reset, rsp_valid_ff, rsp_data_ff.cell_row != '0 && rsp_data_ff.cell_col != '0)

endmodule

### design/jacobi_poisson_stencil_sweep_top.sv
// sequence: the back end takes one cell at a time; an interior cell passes ST_READ, ST_EAST,
//   ST_MUL1, ST_MUL2, ST_SUM, ST_MUL3, ST_CLAMP, ST_DIFF and ST_DONE, and its result is registered
//   once the output is free; a border cell produces no result and leaves after ST_READ and ST_EAST;
//   the sequencer does line-buffer reads, three multiply steps and clamps; a 2-entry queue absorbs input
// reset: synchronous, active high; clears grid position, running max, queue and output valid,
//   loads register defaults; line buffers are not cleared
module jacobi_poisson_stencil_sweep_top
   import jpss_pkg::*;
#(
   parameter int MAX_COLS  = 1024,
   parameter int FRAC_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  req_item_type         req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rsp_item_type         rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]          csr_wdata
);

   localparam int COL_W = $clog2(MAX_COLS + 2);
   localparam int Q_W   = $bits(task_type) + COL_W;

   logic [15:0] kappa_a_ff, kappa_a_in;
   logic [30:0] kappa_sq_ff, kappa_sq_in;
   logic [30:0] dx_sq_ff, dx_sq_in;
   logic [10:0] grid_cols_ff, grid_cols_in;
   logic [15:0] grid_rows_ff, grid_rows_in;

   coef_type         coef;
   dims_type         dims;
   logic             q_push, q_pop, q_full, q_empty;
   task_type         push_task, head_task;
   logic [COL_W-1:0] push_col, head_col;
   logic [Q_W-1:0]   q_wdata, q_rdata;

   assign csr_ready = 1'b1;

   always_comb begin
      kappa_a_in   = kappa_a_ff;
      kappa_sq_in  = kappa_sq_ff;
      dx_sq_in     = dx_sq_ff;
      grid_cols_in = grid_cols_ff;
      grid_rows_in = grid_rows_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_KAPPA_A:   kappa_a_in   = csr_wdata[15:0];
            CSR_KAPPA_SQ:  kappa_sq_in  = csr_wdata[30:0];
            CSR_DX_SQ:     dx_sq_in     = csr_wdata[30:0];
            CSR_GRID_COLS: grid_cols_in = csr_wdata[10:0];
            CSR_GRID_ROWS: grid_rows_in = csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kappa_a_ff   <= KAPPA_A_RST;
         kappa_sq_ff  <= KAPPA_SQ_RST;
         dx_sq_ff     <= DX_SQ_RST;
         grid_cols_ff <= GRID_COLS_RST;
         grid_rows_ff <= GRID_ROWS_RST;
      end else begin
         kappa_a_ff   <= kappa_a_in;
         kappa_sq_ff  <= kappa_sq_in;
         dx_sq_ff     <= dx_sq_in;
         grid_cols_ff <= grid_cols_in;
         grid_rows_ff <= grid_rows_in;
      end
   end

   assign coef.kappa_a   = kappa_a_ff;
   assign coef.kappa_sq  = kappa_sq_ff;
   assign coef.dx_sq     = dx_sq_ff;
   assign dims.grid_cols = grid_cols_ff;
   assign dims.grid_rows = grid_rows_ff;

   jpss_front #(
      .MAX_COLS (MAX_COLS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .dims      (dims),
      .q_full    (q_full),
      .q_push    (q_push),
      .push_task (push_task),
      .push_col  (push_col)
   );

   assign q_wdata = {push_task, push_col};

   jpss_queue #(
      .WIDTH (Q_W)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .wdata (q_wdata),
      .pop   (q_pop),
      .rdata (q_rdata),
      .full  (q_full),
      .empty (q_empty)
   );

   assign head_task = q_rdata[Q_W-1:COL_W];
   assign head_col  = q_rdata[COL_W-1:0];

   jpss_back #(
      .MAX_COLS  (MAX_COLS),
      .FRAC_BITS (FRAC_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .coef      (coef),
      .q_empty   (q_empty),
      .head_task (head_task),
      .head_col  (head_col),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
